// ----- hdl/ntwa_pkg.sv -----
// ----------------------------------------------------------------------------
// ntwa_pkg: shared types and constants for the neighbor table
// Words, table entries and the command and status groups that join the
// controller and the datapath.
// ----------------------------------------------------------------------------
package ntwa_pkg;

  localparam int unsigned DEF_TABLE_DEPTH = 16;
  localparam logic [31:0] MAX_AGE_RESET = 32'd30000;
  localparam logic signed [7:0] RSSI_NONE = -8'sd128;

  localparam logic [1:0] FUNC_HELLO = 2'd0;
  localparam logic [1:0] FUNC_PRUNE = 2'd1;
  localparam logic [1:0] FUNC_READ = 2'd2;

  typedef struct packed {
    logic [1:0] func;
    logic [47:0] mac_addr;
    logic [31:0] base_color;
    logic [31:0] shade_color;
    logic [31:0] fw_version;
    logic signed [7:0] signal_rssi;
    logic [31:0] now_ms;
    logic [3:0] read_index;
  } in_word_t;

  typedef struct packed {
    logic entry_valid;
    logic [47:0] out_mac;
    logic [31:0] out_base_color;
    logic [31:0] out_shade_color;
    logic [31:0] out_fw_version;
    logic [31:0] out_last_seen;
    logic signed [7:0] out_rssi;
    logic [4:0] entry_count;
    logic evicted;
    logic [4:0] removed_count;
  } out_word_t;

  typedef struct packed {
    logic [47:0] mac;
    logic [31:0] base;
    logic [31:0] shade;
    logic [31:0] fw;
    logic [31:0] stamp;
    logic signed [7:0] rssi;
  } entry_t;

  typedef enum logic [1:0] {
    RD_IDX = 2'd0,
    RD_LAST = 2'd1,
    RD_RIX = 2'd2
  } rd_sel_t;

  typedef enum logic [1:0] {
    WA_IDX = 2'd0,
    WA_CNT = 2'd1,
    WA_MIN = 2'd2
  } wa_sel_t;

  typedef enum logic [1:0] {
    WD_NEW = 2'd0,
    WD_MERGE = 2'd1,
    WD_MOVE = 2'd2
  } wd_sel_t;

  typedef struct packed {
    logic load_item;
    logic rd_en;
    rd_sel_t rd_sel;
    logic wr_en;
    wa_sel_t wa_sel;
    wd_sel_t wd_sel;
    logic idx_clr;
    logic idx_inc;
    logic min_step;
    logic cnt_inc;
    logic cnt_dec;
    logic set_evict;
    logic rem_inc;
    logic out_load;
  } ntwa_cmd_t;

  typedef struct packed {
    logic [1:0] func;
    logic cnt_zero;
    logic idx_last;
    logic full;
    logic mac_hit;
    logic prune_hit;
    logic out_free;
  } ntwa_stat_t;

endpackage

// ----- hdl/ntwa_ctrl.sv -----
// ----------------------------------------------------------------------------
// ntwa_ctrl: sequencer for the neighbor table
// Walks the table slot by slot for lookup, eviction scan and prune, and
// issues commands to the datapath.
// ----------------------------------------------------------------------------
module ntwa_ctrl
  import ntwa_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  ntwa_stat_t stat,
  output ntwa_cmd_t  cmd
);

  typedef enum logic [14:0] {
    S_IDLE  = 15'b000000000000001,
    S_DISP  = 15'b000000000000010,
    S_H_RD  = 15'b000000000000100,
    S_H_CMP = 15'b000000000001000,
    S_H_INS = 15'b000000000010000,
    S_E_RD  = 15'b000000000100000,
    S_E_CMP = 15'b000000001000000,
    S_E_LRD = 15'b000000010000000,
    S_E_MOV = 15'b000000100000000,
    S_P_RD  = 15'b000001000000000,
    S_P_CMP = 15'b000010000000000,
    S_P_LRD = 15'b000100000000000,
    S_P_MOV = 15'b001000000000000,
    S_R_RD  = 15'b010000000000000,
    S_FIN   = 15'b100000000000000
  } state_t;

  state_t state_r, state_nxt;

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    cmd.rd_sel = RD_IDX;
    cmd.wa_sel = WA_IDX;
    cmd.wd_sel = WD_NEW;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_item = 1'b1;
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        case (stat.func)
          FUNC_HELLO: state_nxt = stat.cnt_zero ? S_H_INS : S_H_RD;
          FUNC_PRUNE: state_nxt = stat.cnt_zero ? S_FIN : S_P_RD;
          FUNC_READ: state_nxt = S_R_RD;
          default: state_nxt = S_FIN;
        endcase
      end
      S_H_RD: begin
        cmd.rd_en = 1'b1;
        state_nxt = S_H_CMP;
      end
      S_H_CMP: begin
        if (stat.mac_hit) begin
          cmd.wr_en = 1'b1;
          cmd.wd_sel = WD_MERGE;
          state_nxt = S_FIN;
        end else if (!stat.idx_last) begin
          cmd.idx_inc = 1'b1;
          state_nxt = S_H_RD;
        end else if (stat.full) begin
          cmd.idx_clr = 1'b1;
          state_nxt = S_E_RD;
        end else begin
          state_nxt = S_H_INS;
        end
      end
      S_H_INS: begin
        cmd.wr_en = 1'b1;
        cmd.wa_sel = WA_CNT;
        cmd.cnt_inc = 1'b1;
        state_nxt = S_FIN;
      end
      S_E_RD: begin
        cmd.rd_en = 1'b1;
        state_nxt = S_E_CMP;
      end
      S_E_CMP: begin
        cmd.min_step = 1'b1;
        if (stat.idx_last) begin
          state_nxt = S_E_LRD;
        end else begin
          cmd.idx_inc = 1'b1;
          state_nxt = S_E_RD;
        end
      end
      S_E_LRD: begin
        cmd.rd_en = 1'b1;
        cmd.rd_sel = RD_LAST;
        state_nxt = S_E_MOV;
      end
      S_E_MOV: begin
        cmd.wr_en = 1'b1;
        cmd.wa_sel = WA_MIN;
        cmd.wd_sel = WD_MOVE;
        cmd.cnt_dec = 1'b1;
        cmd.set_evict = 1'b1;
        state_nxt = S_H_INS;
      end
      S_P_RD: begin
        cmd.rd_en = 1'b1;
        state_nxt = S_P_CMP;
      end
      S_P_CMP: begin
        if (stat.prune_hit) begin
          state_nxt = S_P_LRD;
        end else if (stat.idx_last) begin
          state_nxt = S_FIN;
        end else begin
          cmd.idx_inc = 1'b1;
          state_nxt = S_P_RD;
        end
      end
      S_P_LRD: begin
        cmd.rd_en = 1'b1;
        cmd.rd_sel = RD_LAST;
        state_nxt = S_P_MOV;
      end
      S_P_MOV: begin
        cmd.wr_en = 1'b1;
        cmd.wd_sel = WD_MOVE;
        cmd.cnt_dec = 1'b1;
        cmd.rem_inc = 1'b1;
        state_nxt = stat.idx_last ? S_FIN : S_P_RD;
      end
      S_R_RD: begin
        cmd.rd_en = 1'b1;
        cmd.rd_sel = RD_RIX;
        state_nxt = S_FIN;
      end
      S_FIN: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ----- hdl/ntwa_dpath.sv -----
// ----------------------------------------------------------------------------
// ntwa_dpath: storage and arithmetic of the neighbor table
// Holds the entry memory, the slot walk index, the count, the oldest-entry
// tracker, the age limit register and the result register.
// ----------------------------------------------------------------------------
module ntwa_dpath
  import ntwa_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = DEF_TABLE_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  in_word_t    in_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_word_t   out_data,
  input  ntwa_cmd_t   cmd,
  output ntwa_stat_t  stat
);

  localparam int unsigned IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);

  entry_t mem [TABLE_DEPTH];
  entry_t rd_r;
  in_word_t item_r;
  logic [IW-1:0] idx_r;
  logic [IW-1:0] min_idx_r;
  logic [31:0] min_stamp_r;
  logic [CW-1:0] cnt_r;
  logic [CW-1:0] rem_r;
  logic evict_r;
  logic [31:0] max_age_r;
  logic out_valid_r;
  out_word_t out_r;
  out_word_t out_nxt;

  logic [CW-1:0] last_w;
  logic [31:0] rix_w;
  logic [IW-1:0] rd_addr, wr_addr;
  entry_t wr_data, new_entry;
  logic [31:0] age_w;
  logic rix_ok;

  assign cfg_ready = 1'b1;
  assign last_w = cnt_r - CW'(1);
  assign rix_w = 32'(item_r.read_index);

  always_comb begin
    case (cmd.rd_sel)
      RD_LAST: rd_addr = last_w[IW-1:0];
      RD_RIX: rd_addr = rix_w[IW-1:0];
      default: rd_addr = idx_r;
    endcase
    case (cmd.wa_sel)
      WA_CNT: wr_addr = cnt_r[IW-1:0];
      WA_MIN: wr_addr = min_idx_r;
      default: wr_addr = idx_r;
    endcase
    new_entry.mac = item_r.mac_addr;
    new_entry.base = item_r.base_color;
    new_entry.shade = item_r.shade_color;
    new_entry.fw = item_r.fw_version;
    new_entry.stamp = item_r.now_ms;
    new_entry.rssi = item_r.signal_rssi;
    case (cmd.wd_sel)
      WD_MERGE: begin
        wr_data = new_entry;
        if (item_r.signal_rssi == RSSI_NONE) begin
          wr_data.rssi = rd_r.rssi;
        end
      end
      WD_MOVE: wr_data = rd_r;
      default: wr_data = new_entry;
    endcase
  end

  // A stamp later than the current time counts as age zero.
  assign age_w = (item_r.now_ms >= rd_r.stamp) ? item_r.now_ms - rd_r.stamp : 32'd0;
  assign rix_ok = (32'(cnt_r) > rix_w);

  assign stat.func = item_r.func;
  assign stat.cnt_zero = (cnt_r == '0);
  assign stat.idx_last = ((CW'(idx_r) + CW'(1)) == cnt_r);
  assign stat.full = (32'(cnt_r) == 32'(TABLE_DEPTH));
  assign stat.mac_hit = (rd_r.mac == item_r.mac_addr);
  assign stat.prune_hit = (rd_r.stamp != 32'd0) && (age_w > max_age_r);
  assign stat.out_free = !out_valid_r || !out_stall;

  // Result word: entry fields only on an in-range read, zero otherwise.
  always_comb begin
    out_nxt = '0;
    out_nxt.entry_count = 5'(cnt_r);
    out_nxt.evicted = evict_r;
    out_nxt.removed_count = 5'(rem_r);
    if ((item_r.func == FUNC_READ) && rix_ok) begin
      out_nxt.entry_valid = 1'b1;
      out_nxt.out_mac = rd_r.mac;
      out_nxt.out_base_color = rd_r.base;
      out_nxt.out_shade_color = rd_r.shade;
      out_nxt.out_fw_version = rd_r.fw;
      out_nxt.out_last_seen = rd_r.stamp;
      out_nxt.out_rssi = rd_r.rssi;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd.rd_en) begin
      rd_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      item_r <= in_data;
    end
    if (cmd.min_step && ((idx_r == '0) || (rd_r.stamp < min_stamp_r))) begin
      min_stamp_r <= rd_r.stamp;
      min_idx_r <= idx_r;
    end
    if (cmd.out_load) begin
      out_r <= out_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
      cnt_r <= '0;
      rem_r <= '0;
      evict_r <= 1'b0;
      max_age_r <= MAX_AGE_RESET;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        max_age_r <= cfg_data;
      end
      if (cmd.load_item || cmd.idx_clr) begin
        idx_r <= '0;
      end else if (cmd.idx_inc) begin
        idx_r <= idx_r + IW'(1);
      end
      if (cmd.cnt_inc) begin
        cnt_r <= cnt_r + CW'(1);
      end else if (cmd.cnt_dec) begin
        cnt_r <= last_w;
      end
      if (cmd.load_item) begin
        rem_r <= '0;
        evict_r <= 1'b0;
      end else begin
        if (cmd.rem_inc) begin
          rem_r <= rem_r + CW'(1);
        end
        if (cmd.set_evict) begin
          evict_r <= 1'b1;
        end
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data = out_r;

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(cnt_r) <= 32'(TABLE_DEPTH))
    else $error("entry count above table depth");

  a_ins_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.cnt_inc |-> !stat.full)
    else $error("insert into a full table");

  a_drop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.cnt_dec |-> !stat.cnt_zero)
    else $error("removal from an empty table");

  a_evict_full: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.set_evict |-> stat.full)
    else $error("eviction while table not full");

  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (32'(rem_r) + 32'(cnt_r)) <= 32'(TABLE_DEPTH))
    else $error("removed plus remaining exceeds depth");

endmodule

// ----- hdl/neighbor_table_with_aging.sv -----
// ----------------------------------------------------------------------------
// neighbor_table_with_aging: MAC-keyed neighbor table with aging
// Top level joining the sequencer and the table datapath.
// ----------------------------------------------------------------------------
// The block keeps up to TABLE_DEPTH neighbor entries in one single-port-write
// memory, packed densely from slot zero. A word is accepted only while the
// sequencer is idle, so one word is worked at a time; the result word sits in
// an output register, so the next input word can be taken while it waits.
// Every slot visit reads the memory, then acts on the registered data. A
// read fetches only the slot named by its read index. A hello walks the
// slots and stops to merge into the slot that holds its address, else it
// inserts the new entry in the slot after the last; when the table is full
// and the address is new, the scan for the oldest stamp and the move of the
// last entry into its slot come first. A prune walks the entries and moves
// the last entry into the slot of each entry removed. A stalled output
// register holds the finished item until it drains. The age limit is
// written through the cfg port, which is always ready.
module neighbor_table_with_aging
  import ntwa_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = DEF_TABLE_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_word_t    in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_word_t   out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_data
);

  // Command and status groups between sequencer and datapath.
  ntwa_cmd_t cmd;
  ntwa_stat_t stat;

  ntwa_ctrl u_ctrl (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .stat(stat),
    .cmd(cmd)
  );

  ntwa_dpath #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_dpath (
    .clk(clk),
    .rst_n(rst_n),
    .in_data(in_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data),
    .cmd(cmd),
    .stat(stat)
  );

endmodule
